FILE: rtl/fpnsr_pkg.sv
// Package with the fixed field widths of the factor pair block.
package fpnsr_pkg;

    // Port widths of the value and the two factors.
    localparam int unsigned VALUE_W = 31;
    localparam int unsigned LARGE_W = 31;
    localparam int unsigned SMALL_W = 16;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [LARGE_W-1:0] t_large;
    typedef logic [SMALL_W-1:0] t_small;

endpackage

FILE: rtl/factor_pair_near_square_root.sv
// Factor pair near the square root: bit-serial square root and trial division.
//
// Channel  Direction  Handshake           Payload
// -------  ---------  ------------------  -------------------------------
// input    in         i_valid / o_stall   i_value
// output   out        o_valid / i_stall   o_factor_large, o_factor_small
//
// A request is taken, the square root is found, candidate divisors are tried from the root
// downward (one quotient bit a cycle) and the result is then finished.
// Value 0 skips both the root and the search.
// Reset is synchronous and clears the control state; there is no clearing pass.
// A new request is taken while the previous result still waits in the output register.
// A finished result waits, with the input stalled, until the output register drains.
module factor_pair_near_square_root #(
    parameter int unsigned VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  fpnsr_pkg::t_value     i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output fpnsr_pkg::t_large     o_factor_large,
    output fpnsr_pkg::t_small     o_factor_small
);

    localparam int unsigned W  = VALUE_BITS;
    localparam int unsigned SW = (W + 1) / 2;
    localparam int unsigned RW = SW + 2;
    localparam int unsigned CW = $clog2(W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQRT,
        S_DIV,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [W-1:0]      r_value;
    logic [2*SW-1:0]   r_sq_sh;
    logic [RW-1:0]     r_sq_rem;
    logic [SW-1:0]     r_root;
    logic [SW-1:0]     r_k;
    logic [W-1:0]      r_div_sh;
    logic [SW-1:0]     r_div_rem;
    logic [CW-1:0]     r_cnt;
    logic              r_out_valid;
    fpnsr_pkg::t_large r_out_large;
    fpnsr_pkg::t_small r_out_small;

    logic [W-1:0]      n_in_value;
    logic [RW+1:0]     n_sq_ext;
    logic [RW+1:0]     n_sq_trial;
    logic              n_sq_fit;
    logic [RW-1:0]     n_sq_rem;
    logic [SW-1:0]     n_root;
    logic [SW:0]       n_div_ext;
    logic              n_div_fit;
    logic [SW-1:0]     n_div_rem;
    logic [W-1:0]      n_div_sh;
    logic              n_out_free;

    assign n_in_value = W'(i_value);

    // One root bit a cycle: bring down two value bits and try (root << 2) | 1.
    assign n_sq_ext   = {r_sq_rem, r_sq_sh[2*SW-1 -: 2]};
    assign n_sq_trial = (RW+2)'({r_root, 2'b01});
    assign n_sq_fit   = (n_sq_ext >= n_sq_trial);
    assign n_sq_rem   = n_sq_fit ? RW'(n_sq_ext - n_sq_trial) : RW'(n_sq_ext);
    assign n_root     = {r_root[SW-2:0], n_sq_fit};

    // One quotient bit a cycle: bring down one value bit and try the divisor.
    assign n_div_ext = {r_div_rem, r_div_sh[W-1]};
    assign n_div_fit = (n_div_ext >= (SW+1)'(r_k));
    assign n_div_rem = n_div_fit ? SW'(n_div_ext - (SW+1)'(r_k)) : SW'(n_div_ext);
    assign n_div_sh  = {r_div_sh[W-2:0], n_div_fit};

    // The output register can take a result when empty or when drained now.
    assign n_out_free = !r_out_valid || !i_stall;

    // Sequencer, datapath registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_value  <= n_in_value;
                        r_sq_sh  <= (2*SW)'(n_in_value);
                        r_sq_rem <= '0;
                        r_root   <= '0;
                        r_cnt    <= CW'(SW - 1);
                        if (n_in_value == '0) begin
                            // Zero gives the pair zero and zero.
                            r_k      <= '0;
                            r_div_sh <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state  <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    r_sq_sh  <= {r_sq_sh[2*SW-3:0], 2'b00};
                    r_sq_rem <= n_sq_rem;
                    r_root   <= n_root;
                    if (r_cnt == '0) begin
                        // The root is the first candidate divisor.
                        r_k       <= n_root;
                        r_div_sh  <= r_value;
                        r_div_rem <= '0;
                        r_cnt     <= CW'(W - 1);
                        r_state   <= S_DIV;
                    end else begin
                        r_cnt     <= r_cnt - CW'(1);
                    end
                end
                S_DIV: begin
                    if (r_cnt != '0) begin
                        r_div_sh  <= n_div_sh;
                        r_div_rem <= n_div_rem;
                        r_cnt     <= r_cnt - CW'(1);
                    end else if (n_div_rem == '0) begin
                        // Divisor found; the quotient is the large factor.
                        r_div_sh  <= n_div_sh;
                        r_div_rem <= n_div_rem;
                        r_state   <= S_DONE;
                    end else begin
                        // Try the next smaller candidate; one always divides.
                        r_k       <= r_k - SW'(1);
                        r_div_sh  <= r_value;
                        r_div_rem <= '0;
                        r_cnt     <= CW'(W - 1);
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_large <= fpnsr_pkg::t_large'(r_div_sh);
                        r_out_small <= fpnsr_pkg::t_small'(r_k);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_factor_large = r_out_large;
    assign o_factor_small = r_out_small;

`ifndef SYNTHESIS
    // The candidate divisor never reaches zero during the search.
    a_k_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_k != '0))
        else $error("candidate divisor is zero during division");

    // A new result appears only on the way out of the done state.
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("result shown without finishing a request");

    // An accepted request blocks the input until its result is handed over.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepting a request");

    // A nonzero value only finishes with an exact division.
    a_exact_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_value != '0) |-> (r_div_rem == '0))
        else $error("finished with a nonzero remainder");
`endif

endmodule
